@@ rtl/core/set_assoc_lru_cache_tags_unit_macros.svh @@
// Assertion macros for the cache tag unit
`ifndef SET_ASSOC_LRU_CACHE_TAGS_UNIT_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_TAGS_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define SALC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SALC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/salc_pkg.sv @@
// Types, constants and helpers shared by the cache tag unit
package salc_pkg;

  localparam int unsigned MAX_WAYS = 8;
  localparam int unsigned NUM_SETS = 256;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned TAG_W    = 30;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned CFG_W    = 4;
  localparam int unsigned SET_W    = $clog2(NUM_SETS);
  localparam int unsigned WAY_W    = $clog2(MAX_WAYS);
  localparam int unsigned WAYS_W   = $clog2(MAX_WAYS + 1);
  localparam int unsigned AGE_W    = $clog2(MAX_WAYS);
  localparam int unsigned SHIFT_W  = CFG_W + 1;

  localparam logic [CFG_W-1:0]  OFF_MIN   = CFG_W'(2);
  localparam logic [CFG_W-1:0]  OFF_MAX   = CFG_W'(8);
  localparam logic [CFG_W-1:0]  IDX_MAX   = CFG_W'(SET_W);
  localparam logic [CFG_W-1:0]  OFF_RST   = CFG_W'(4);
  localparam logic [CFG_W-1:0]  IDX_RST   = CFG_W'(6);
  localparam logic [CFG_W-1:0]  WAYS_RST  = CFG_W'(4);
  localparam logic [CFG_W-1:0]  WAYS_MAXC = CFG_W'(MAX_WAYS);
  localparam logic [SET_W-1:0]  SET_LAST  = SET_W'(NUM_SETS - 1);
  localparam logic [AGE_W-1:0]  AGE_MAX   = AGE_W'(MAX_WAYS - 1);
  localparam logic [AGE_W:0]    LIMIT_ALL = (AGE_W + 1)'(MAX_WAYS);

  typedef enum logic [1:0] {
    CFG_OFFSET_BITS = 2'd0,
    CFG_INDEX_BITS  = 2'd1,
    CFG_WAYS_IN_USE = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic [AGE_W-1:0] age;
    logic [TAG_W-1:0] tag;
  } line_t;

  typedef line_t [MAX_WAYS-1:0] row_t;

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] hit_way;
    logic             inv_found;
    logic [WAY_W-1:0] inv_way;
    logic [WAY_W-1:0] old_way;
    logic [AGE_W-1:0] old_age;
  } scan_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

endpackage

@@ rtl/core/salc_row_ram.sv @@
// Set-row memory: one row of all ways per set, one write and one registered read port
module salc_row_ram
  import salc_pkg::*;
(
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [SET_W-1:0] waddr_i,
  input  row_t             wdata_i,
  input  logic             re_i,
  input  logic [SET_W-1:0] raddr_i,
  output row_t             rdata_o
);

  row_t mem_q [NUM_SETS];
  row_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/salc_way_scan.sv @@
// Shared way compare unit: examines one way per step, tracks hit, first free and oldest way
module salc_way_scan
  import salc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic             step_i,
  input  logic [WAY_W-1:0] way_i,
  input  line_t            line_i,
  input  logic [TAG_W-1:0] tag_i,
  output scan_t            res_o
);

  scan_t res_q, res_d;

  always_comb begin
    res_d = res_q;
    if (clear_i) begin
      res_d = '0;
    end else if (step_i) begin
      if (line_i.valid && (line_i.tag == tag_i) && !res_q.hit) begin
        res_d.hit     = 1'b1;
        res_d.hit_way = way_i;
      end
      if (!line_i.valid && !res_q.inv_found) begin
        res_d.inv_found = 1'b1;
        res_d.inv_way   = way_i;
      end
      if (line_i.age > res_q.old_age) begin
        res_d.old_age = line_i.age;
        res_d.old_way = way_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

@@ rtl/core/set_assoc_lru_cache_tags_unit.sv @@
// Top level of the set-associative LRU cache tag unit
//
//  channel   direction  transfer when                 payload
//  access    in         start & !busy                 address_i, is_write_i
//  config    in         cfg_valid_i & cfg_ready_o     cfg_index_i, cfg_data_i
//  result    out        done_o (one cycle)            hit_o, writeback_o, *_total_o
//
// Each access runs these steps before the next one can be accepted: one set-row
// read, one way per cycle through the shared compare unit, one row write-back.
// done_o pulses the cycle after the row write; the receiver cannot stall it.
// After reset a clearing pass writes all 256 set rows, one per cycle; busy stays high.
// Configuration writes are taken at any time.
module set_assoc_lru_cache_tags_unit
  import salc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [ADDR_W-1:0] address_i,
  input  logic              is_write_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  output logic              done_o,
  output logic              hit_o,
  output logic              writeback_o,
  output logic [CNT_W-1:0]  access_total_o,
  output logic [CNT_W-1:0]  hit_total_o,
  output logic [CNT_W-1:0]  miss_total_o,
  output logic [CNT_W-1:0]  writeback_total_o
);

`include "set_assoc_lru_cache_tags_unit_macros.svh"

  state_e state_q, state_d;
  logic [SET_W-1:0] clr_cnt_q, clr_cnt_d;
  logic [WAY_W-1:0] way_q, way_d;

  logic [CFG_W-1:0] offset_bits_q, index_bits_q, ways_in_use_q;
  logic [CFG_W-1:0] ob_eff, ib_eff, ways_eff, ways_last;

  logic [ADDR_W-1:0] addr_q;
  logic              wr_q;
  logic [SET_W-1:0]  set_q, set_d;
  logic [TAG_W-1:0]  tag_q, tag_d;
  logic [ADDR_W-1:0] shifted;
  logic [SET_W-1:0]  set_mask;

  logic             ram_we, ram_re;
  logic [SET_W-1:0] ram_waddr;
  row_t             ram_wdata, row_rd, row_new;

  logic  scan_clear, scan_step, upd;
  scan_t scan_res;

  logic [WAY_W-1:0] tgt_way;
  logic [AGE_W:0]   limit;
  logic             wb_now;

  logic [CNT_W-1:0] acc_cnt_q, hit_cnt_q, miss_cnt_q, wb_cnt_q;
  logic             done_q, hit_q, wb_q;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_bits_q <= OFF_RST;
      index_bits_q  <= IDX_RST;
      ways_in_use_q <= WAYS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_OFFSET_BITS: offset_bits_q <= cfg_data_i;
        CFG_INDEX_BITS:  index_bits_q  <= cfg_data_i;
        CFG_WAYS_IN_USE: ways_in_use_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign ob_eff    = (offset_bits_q < OFF_MIN) ? OFF_MIN :
                     (offset_bits_q > OFF_MAX) ? OFF_MAX : offset_bits_q;
  assign ib_eff    = (index_bits_q > IDX_MAX) ? IDX_MAX : index_bits_q;
  assign ways_eff  = (ways_in_use_q == '0) ? CFG_W'(1) :
                     (ways_in_use_q > WAYS_MAXC) ? WAYS_MAXC : ways_in_use_q;
  assign ways_last = ways_eff - CFG_W'(1);

  // address split
  assign shifted  = addr_q >> ob_eff;
  assign set_mask = ~({SET_W{1'b1}} << ib_eff);
  assign set_d    = shifted[SET_W-1:0] & set_mask;
  assign tag_d    = TAG_W'(addr_q >> (SHIFT_W'(ob_eff) + SHIFT_W'(ib_eff)));

  // sequencer
  always_comb begin
    state_d    = state_q;
    clr_cnt_d  = clr_cnt_q;
    way_d      = way_q;
    ram_we     = 1'b0;
    ram_waddr  = set_q;
    ram_wdata  = row_new;
    ram_re     = 1'b0;
    scan_clear = 1'b0;
    scan_step  = 1'b0;
    upd        = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
        clr_cnt_d = clr_cnt_q + SET_W'(1);
        if (clr_cnt_q == SET_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        ram_re     = 1'b1;
        scan_clear = 1'b1;
        way_d      = '0;
        state_d    = ST_SCAN;
      end
      ST_SCAN: begin
        scan_step = 1'b1;
        way_d     = way_q + WAY_W'(1);
        if (CFG_W'(way_q) == ways_last) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        ram_we  = 1'b1;
        upd     = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      way_q     <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      way_q     <= way_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      addr_q <= address_i;
      wr_q   <= is_write_i;
    end
    if (state_q == ST_LOOKUP) begin
      set_q <= set_d;
      tag_q <= tag_d;
    end
  end

  salc_row_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (set_d),
    .rdata_o (row_rd)
  );

  salc_way_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (scan_clear),
    .step_i  (scan_step),
    .way_i   (way_q),
    .line_i  (row_rd[way_q]),
    .tag_i   (tag_q),
    .res_o   (scan_res)
  );

  // row update
  always_comb begin
    tgt_way = scan_res.hit ? scan_res.hit_way :
              scan_res.inv_found ? scan_res.inv_way : scan_res.old_way;
    limit   = (!scan_res.hit && scan_res.inv_found) ? LIMIT_ALL :
              {1'b0, row_rd[tgt_way].age};
    wb_now  = !scan_res.hit && !scan_res.inv_found && row_rd[tgt_way].dirty;
    row_new = row_rd;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if ((CFG_W'(w) < ways_eff) && row_rd[w].valid &&
          ({1'b0, row_rd[w].age} < limit) && (row_rd[w].age < AGE_MAX)) begin
        row_new[w].age = row_rd[w].age + AGE_W'(1);
      end
    end
    row_new[tgt_way].age = '0;
    if (scan_res.hit) begin
      row_new[tgt_way].dirty = row_rd[tgt_way].dirty | wr_q;
    end else begin
      row_new[tgt_way].valid = 1'b1;
      row_new[tgt_way].tag   = tag_q;
      row_new[tgt_way].dirty = wr_q;
    end
  end

  // counters and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_cnt_q  <= '0;
      hit_cnt_q  <= '0;
      miss_cnt_q <= '0;
      wb_cnt_q   <= '0;
      done_q     <= 1'b0;
      hit_q      <= 1'b0;
      wb_q       <= 1'b0;
    end else begin
      done_q <= upd;
      if (upd) begin
        acc_cnt_q <= sat_inc(acc_cnt_q);
        hit_q     <= scan_res.hit;
        wb_q      <= wb_now;
        if (scan_res.hit) begin
          hit_cnt_q <= sat_inc(hit_cnt_q);
        end else begin
          miss_cnt_q <= sat_inc(miss_cnt_q);
        end
        if (wb_now) begin
          wb_cnt_q <= sat_inc(wb_cnt_q);
        end
      end
    end
  end

  assign done_o            = done_q;
  assign hit_o             = hit_q;
  assign writeback_o       = wb_q;
  assign access_total_o    = acc_cnt_q;
  assign hit_total_o       = hit_cnt_q;
  assign miss_total_o      = miss_cnt_q;
  assign writeback_total_o = wb_cnt_q;

  `SALC_ASSERT_NEXT(a_update_done, state_q == ST_UPDATE, done_o, "no result after row update")
  `SALC_ASSERT_NOW(a_hit_no_wb, done_o, !(hit_o && writeback_o), "writeback reported on a hit")
  `SALC_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done_o, "access accepted but not busy")
  `SALC_ASSERT_NOW(a_done_idle, done_o, state_q == ST_IDLE, "result strobe outside idle")

endmodule
